// File: sv/adq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adq_pkg
// Operation and status codes shared by the array deque and its channels.
// ----------------------------------------------------------------------------
package adq_pkg;

	// Operation codes carried on the command channel
	typedef enum logic [2:0] {
		OP_RESTART    = 3'd0,
		OP_LOAD       = 3'd1,
		OP_GET        = 3'd2,
		OP_CHANGE     = 3'd3,
		OP_POP_BACK   = 3'd4,
		OP_POP_FRONT  = 3'd5,
		OP_PUSH_FRONT = 3'd6,
		OP_PUSH_BACK  = 3'd7
	} op_t;

	// Status codes returned with every result
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_RANGE      = 3'd1,
		ST_FULL_FRONT = 3'd2,
		ST_FULL_BACK  = 3'd3,
		ST_EMPTY      = 3'd4
	} status_t;

	localparam int VALUE_W = 32;
	localparam int INDEX_W = 8;
	localparam int COUNT_W = 9;

endpackage
`default_nettype wire

// File: sv/adq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adq_cmd_if / adq_rsp_if / adq_cfg_if
// Valid/ready channels of the array deque: commands in, results out and
// the capacity register write.
// ----------------------------------------------------------------------------
interface adq_cmd_if;
	import adq_pkg::*;

	logic                       valid;
	logic                       ready;
	op_t                        operation;
	logic        [INDEX_W-1:0]  index;
	logic signed [VALUE_W-1:0]  value;

	modport source (output valid, output operation, output index, output value,
		input ready);
	modport sink (input valid, input operation, input index, input value,
		output ready);
endinterface

interface adq_rsp_if;
	import adq_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  read_value;
	status_t                    status;
	logic        [COUNT_W-1:0]  count;

	modport source (output valid, output read_value, output status, output count,
		input ready);
	modport sink (input valid, input read_value, input status, input count,
		output ready);
endinterface

interface adq_cfg_if;
	import adq_pkg::*;

	logic                       valid;
	logic                       ready;
	logic        [COUNT_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/adq_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adq_store
// Single-port slot memory: one read or one write per cycle, registered
// read data that holds until the next read.
// ----------------------------------------------------------------------------
module adq_store #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic                        we,
	input  wire logic [ADDR_W-1:0]           addr,
	input  wire logic [adq_pkg::VALUE_W-1:0] wdata,
	output logic      [adq_pkg::VALUE_W-1:0] rdata
);
	import adq_pkg::*;

	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	// Write or read the addressed slot
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: sv/array_deque_with_index_access.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// array_deque_with_index_access
// Double-ended queue over a fixed slot memory with window-relative access; load writes absolute slots.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  : one operation per transfer (operation, index, value).
//   rsp  : one result per command (read_value, status, count), in order.
//   cfg  : writes the capacity register; always ready. Write it only while
//          no command is in flight.
// Timing: a command is decided in the cycle it is accepted. Window pointers
//   update at that edge and the slot memory is read or written at the same
//   edge; the result passes through the read stage and the result register
//   to rsp. The block takes one command per cycle while rsp is not held off:
//   every command makes at most one slot access on the single memory port,
//   and reads land after any earlier write.
// Reset: the window is empty at start slot zero and capacity is 256 (or the
//   slot depth if smaller). Slot contents are undefined until loaded.
// Stall: when rsp is held off, the result register and the read stage hold;
//   cmd.ready drops once both are full and rises as soon as rsp takes one.
// ----------------------------------------------------------------------------
module array_deque_with_index_access #(
	parameter int SLOT_DEPTH = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	adq_cmd_if.sink    cmd,
	adq_rsp_if.source  rsp,
	adq_cfg_if.sink    cfg
);
	import adq_pkg::*;

	localparam int ADDR_W = $clog2(SLOT_DEPTH);
	localparam int SUM_W  = (ADDR_W > 10) ? ADDR_W : 10;
	localparam logic [COUNT_W-1:0] DEPTH_CAP =
		(SLOT_DEPTH >= 511) ? 9'd511 : COUNT_W'(SLOT_DEPTH);
	localparam logic [COUNT_W-1:0] RESET_CAP =
		(SLOT_DEPTH >= 256) ? 9'd256 : COUNT_W'(SLOT_DEPTH);
	localparam logic [COUNT_W-1:0] LOAD_LIM = RESET_CAP;
	localparam logic [COUNT_W-1:0] ONE      = COUNT_W'(1);

	// Window and capacity state
	logic [COUNT_W-1:0] cap_eff_q;
	logic [COUNT_W-1:0] start_q;
	logic [COUNT_W-1:0] len_q;

	// Read stage and result register
	logic               valid_s1;
	logic               read_s1;
	status_t            status_s1;
	logic [COUNT_W-1:0] count_s1;
	logic               out_valid_q;
	logic [VALUE_W-1:0] read_value_q;
	status_t            status_q;
	logic [COUNT_W-1:0] count_q;

	// Decode outputs
	logic               cmd_fire;
	logic               s1_move;
	logic [COUNT_W-1:0] next_start;
	logic [COUNT_W-1:0] next_len;
	status_t            status_d;
	logic               mem_en;
	logic               mem_we;
	logic               read_d;
	logic [SUM_W-1:0]   mem_addr;
	logic [VALUE_W-1:0] mem_rdata;
	logic [COUNT_W-1:0] idx9;
	logic [COUNT_W:0]   end10;
	logic               in_window;

	assign s1_move  = !out_valid_q || rsp.ready;
	assign cmd.ready = !valid_s1 || s1_move;
	assign cmd_fire = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;

	assign idx9      = {1'b0, cmd.index};
	assign end10     = {1'b0, start_q} + {1'b0, len_q};
	assign in_window = idx9 < len_q;

	// Decide the operation against the current window
	always_comb begin
		next_start = start_q;
		next_len   = len_q;
		status_d   = ST_OK;
		mem_en     = 1'b0;
		mem_we     = 1'b0;
		read_d     = 1'b0;
		mem_addr   = SUM_W'(idx9);
		case (cmd.operation)
			OP_RESTART: begin
				next_start = '0;
				next_len   = cap_eff_q;
			end
			OP_LOAD: begin
				if (idx9 < LOAD_LIM) begin
					mem_en = 1'b1;
					mem_we = 1'b1;
				end else begin
					status_d = ST_RANGE;
				end
			end
			OP_GET: begin
				mem_addr = SUM_W'(start_q) + SUM_W'(idx9);
				if (in_window) begin
					mem_en = 1'b1;
					read_d = 1'b1;
				end else begin
					status_d = ST_RANGE;
				end
			end
			OP_CHANGE: begin
				mem_addr = SUM_W'(start_q) + SUM_W'(idx9);
				if (in_window) begin
					mem_en = 1'b1;
					mem_we = 1'b1;
				end else begin
					status_d = ST_RANGE;
				end
			end
			OP_POP_BACK: begin
				mem_addr = SUM_W'(end10) - SUM_W'(1);
				if (len_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					mem_en   = 1'b1;
					read_d   = 1'b1;
					next_len = len_q - ONE;
				end
			end
			OP_POP_FRONT: begin
				mem_addr = SUM_W'(start_q);
				if (len_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					mem_en     = 1'b1;
					read_d     = 1'b1;
					next_start = start_q + ONE;
					next_len   = len_q - ONE;
				end
			end
			OP_PUSH_FRONT: begin
				mem_addr = SUM_W'(start_q) - SUM_W'(1);
				if (start_q == '0) begin
					status_d = ST_FULL_FRONT;
				end else begin
					mem_en     = 1'b1;
					mem_we     = 1'b1;
					next_start = start_q - ONE;
					next_len   = len_q + ONE;
				end
			end
			OP_PUSH_BACK: begin
				mem_addr = SUM_W'(end10);
				if (end10 < {1'b0, cap_eff_q}) begin
					mem_en   = 1'b1;
					mem_we   = 1'b1;
					next_len = len_q + ONE;
				end else begin
					status_d = ST_FULL_BACK;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Slot memory
	adq_store #(
		.DEPTH  (SLOT_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.en    (mem_en && cmd_fire),
		.we    (mem_we),
		.addr  (mem_addr[ADDR_W-1:0]),
		.wdata (cmd.value),
		.rdata (mem_rdata)
	);

	// Hold capacity, clamped to the slot depth (at most 511)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_eff_q <= RESET_CAP;
		end else if (cfg.valid) begin
			cap_eff_q <= (cfg.data > DEPTH_CAP) ? DEPTH_CAP : cfg.data;
		end
	end

	// Advance window pointers on each command transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			len_q   <= '0;
		end else if (cmd_fire) begin
			start_q <= next_start;
			len_q   <= next_len;
		end
	end

	// Read stage: wait for memory data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			read_s1   <= read_d;
			status_s1 <= status_d;
			count_s1  <= next_len;
		end
	end

	// Result register toward rsp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			read_value_q <= read_s1 ? mem_rdata : '0;
			status_q     <= status_s1;
			count_q      <= count_s1;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.status     = status_q;
	assign rsp.count      = count_q;

endmodule
`default_nettype wire
